### hw/rtl/two_byte_supply_message_receiver_defines.svh
// assertion macros for the two-byte supply message receiver
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef TWO_BYTE_SUPPLY_MESSAGE_RECEIVER_DEFINES_SVH
`define TWO_BYTE_SUPPLY_MESSAGE_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
`define TBSMR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbsmr same-cycle check failed");
`define TBSMR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbsmr next-cycle check failed");
`else
`define TBSMR_ASSERT_IMP(label, clk, rst, ante, cons)
`define TBSMR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/tbsmr_pkg.sv
// shared types and constants for the two-byte supply message receiver
// no dependencies
package tbsmr_pkg;

   localparam int unsigned CurrentWidth = 35;
   localparam int unsigned PointWidth   = 10;

   // result kinds
   localparam logic [2:0] KIND_UNFRAMED   = 3'd0;
   localparam logic [2:0] KIND_STARTED    = 3'd1;
   localparam logic [2:0] KIND_STOPPED    = 3'd2;
   localparam logic [2:0] KIND_STOP_FAULT = 3'd3;
   localparam logic [2:0] KIND_COMM_FAULT = 3'd4;
   localparam logic [2:0] KIND_CUR_OK     = 3'd5;
   localparam logic [2:0] KIND_CUR_BAD    = 3'd6;

   // register indexes
   localparam logic [2:0] REG_STARTED_CODE    = 3'd0;
   localparam logic [2:0] REG_STOPPED_CODE    = 3'd1;
   localparam logic [2:0] REG_STOP_FAULT_CODE = 3'd2;
   localparam logic [2:0] REG_COMM_FAULT_CODE = 3'd3;
   localparam logic [2:0] REG_ZERO_POINT      = 3'd4;
   localparam logic [2:0] REG_CURRENT_STEP    = 3'd5;
   localparam logic [2:0] REG_FRAMING_MASK    = 3'd6;

   // complement check and scale point masks
   localparam logic [7:0] CHECK_HIGH_MASK = 8'hF0;
   localparam logic [7:0] CHECK_LOW_MASK  = 8'h1E;
   localparam logic [9:0] POINT_LOW_MASK  = 10'h0E0;
   localparam logic [9:0] POINT_HIGH_MASK = 10'h0FE;

   typedef struct packed {
      logic [15:0] started_code;
      logic [15:0] stopped_code;
      logic [15:0] stop_fault_code;
      logic [15:0] comm_fault_code;
      logic [9:0]  zero_point;
      logic [23:0] current_step;
      logic [7:0]  framing_mask;
   } cfg_type;

   typedef struct packed {
      logic [2:0]                     kind;
      logic [PointWidth-1:0]          scale_point;
      logic signed [CurrentWidth-1:0] current_value;
   } decode_type;

endpackage

### hw/rtl/two_byte_supply_message_receiver.sv
// Two-byte supply message receiver.
// Request channel: one received byte per transfer on req_rx_byte (req_valid,
// req_stall). Result channel: one result per completed two-byte message on
// the rsp_ ports (rsp_valid, rsp_stall). Configuration: csr_valid/csr_ready
// write port, csr_index selects the register, csr_wdata carries the value;
// csr_ready is always high and unknown indexes are ignored.
// A byte is taken into an input register; from there, once it may advance,
// it updates the framing state and, when it completes a message, is
// classified, scaled and loaded into the result register, which drives
// result valid. One byte is taken every cycle while req_stall is low;
// the input register holds a message-completing byte only while the
// result register is full and stalled, so req_stall rises one byte behind
// a stalled result.
// Reset clears framing state, flags, the bad run count and both valid
// registers, and loads register defaults (zero point 512, step 1.0,
// framing mask 1).
`include "two_byte_supply_message_receiver_defines.svh"
module two_byte_supply_message_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_msg_kind,
   output logic signed [34:0] rsp_current_value,
   output logic [9:0]  rsp_scale_point,
   output logic        rsp_partial_dropped,
   output logic        rsp_supply_started,
   output logic        rsp_stop_failed,
   output logic        rsp_link_failed,
   output logic [15:0] rsp_bad_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import tbsmr_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   decode_type  dec;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;

   logic        have_first_ff, have_first_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic        start_seen_ff, start_seen_in;
   logic        drop_pending_ff, drop_pending_in;
   logic        started_ff, started_in;
   logic        stop_fault_ff, stop_fault_in;
   logic        comm_fault_ff, comm_fault_in;
   logic [15:0] bad_count_ff, bad_count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic signed [CurrentWidth-1:0] current_ff, current_in;
   logic [PointWidth-1:0] point_ff, point_in;
   logic        dropped_ff, dropped_in;

   logic        is_start, emits, advance, load_rsp;

   // configuration writes
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_STARTED_CODE:    cfg_in.started_code    = csr_wdata[15:0];
            REG_STOPPED_CODE:    cfg_in.stopped_code    = csr_wdata[15:0];
            REG_STOP_FAULT_CODE: cfg_in.stop_fault_code = csr_wdata[15:0];
            REG_COMM_FAULT_CODE: cfg_in.comm_fault_code = csr_wdata[15:0];
            REG_ZERO_POINT:      cfg_in.zero_point      = csr_wdata[9:0];
            REG_CURRENT_STEP:    cfg_in.current_step    = csr_wdata;
            REG_FRAMING_MASK:    cfg_in.framing_mask    = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   tbsmr_decode u_decode (
      .first_byte  (first_byte_ff),
      .second_byte (s1_byte_ff),
      .cfg         (cfg_ff),
      .dec         (dec)
   );

   // handshake and stage movement
   assign is_start  = (s1_byte_ff & cfg_ff.framing_mask) == 8'h00;
   assign emits     = !is_start && have_first_ff;
   assign advance   = s1_valid_ff && (!emits || !rsp_valid_ff || !rsp_stall);
   assign load_rsp  = advance && emits;
   assign req_stall = s1_valid_ff && !advance;
   assign s1_valid_in = req_valid ? 1'b1 : (s1_valid_ff && !advance);

   // framing state and flags
   always_comb begin
      have_first_in   = have_first_ff;
      first_byte_in   = first_byte_ff;
      start_seen_in   = start_seen_ff;
      drop_pending_in = drop_pending_ff;
      started_in      = started_ff;
      stop_fault_in   = stop_fault_ff;
      comm_fault_in   = comm_fault_ff;
      bad_count_in    = bad_count_ff;
      kind_in         = KIND_UNFRAMED;
      current_in      = '0;
      point_in        = '0;
      dropped_in      = drop_pending_ff;
      if (advance) begin
         if (is_start) begin
            if (have_first_ff) begin
               drop_pending_in = 1'b1;
            end
            start_seen_in = 1'b1;
            have_first_in = 1'b1;
            first_byte_in = s1_byte_ff;
         end else if (!have_first_ff) begin
            have_first_in = 1'b1;
            first_byte_in = s1_byte_ff;
         end else begin
            have_first_in   = 1'b0;
            drop_pending_in = 1'b0;
            if (start_seen_ff) begin
               start_seen_in = 1'b0;
               kind_in       = dec.kind;
               current_in    = dec.current_value;
               point_in      = dec.scale_point;
               case (dec.kind)
                  KIND_STARTED:    started_in    = 1'b1;
                  KIND_STOPPED:    started_in    = 1'b0;
                  KIND_STOP_FAULT: stop_fault_in = 1'b1;
                  KIND_COMM_FAULT: comm_fault_in = 1'b1;
                  KIND_CUR_OK:     bad_count_in  = '0;
                  KIND_CUR_BAD: begin
                     if (bad_count_ff != 16'hFFFF) begin
                        bad_count_in = bad_count_ff + 16'd1;
                     end
                  end
                  default:         bad_count_in  = bad_count_ff;
               endcase
            end
         end
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff          <= '{started_code: 16'h0000, stopped_code: 16'h0000,
                              stop_fault_code: 16'h0000, comm_fault_code: 16'h0000,
                              zero_point: 10'd512, current_step: 24'd65536,
                              framing_mask: 8'h01};
         s1_valid_ff     <= 1'b0;
         have_first_ff   <= 1'b0;
         first_byte_ff   <= 8'h00;
         start_seen_ff   <= 1'b0;
         drop_pending_ff <= 1'b0;
         started_ff      <= 1'b0;
         stop_fault_ff   <= 1'b0;
         comm_fault_ff   <= 1'b0;
         bad_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cfg_ff          <= cfg_in;
         s1_valid_ff     <= s1_valid_in;
         have_first_ff   <= have_first_in;
         first_byte_ff   <= first_byte_in;
         start_seen_ff   <= start_seen_in;
         drop_pending_ff <= drop_pending_in;
         started_ff      <= started_in;
         stop_fault_ff   <= stop_fault_in;
         comm_fault_ff   <= comm_fault_in;
         bad_count_ff    <= bad_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff <= req_rx_byte;
      end
      if (load_rsp) begin
         kind_ff    <= kind_in;
         current_ff <= current_in;
         point_ff   <= point_in;
         dropped_ff <= dropped_in;
      end
   end

   // flags and run count are live state; they only move on a result load
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_msg_kind        = kind_ff;
   assign rsp_current_value   = current_ff;
   assign rsp_scale_point     = point_ff;
   assign rsp_partial_dropped = dropped_ff;
   assign rsp_supply_started  = started_ff;
   assign rsp_stop_failed     = stop_fault_ff;
   assign rsp_link_failed     = comm_fault_ff;
   assign rsp_bad_run         = bad_count_ff;

   // flag state that sits behind a held result must not move under it
   `TBSMR_ASSERT_NXT(a_flags_hold, clock, reset, rsp_valid_ff && rsp_stall, $stable(bad_count_ff) && $stable(started_ff) && $stable(stop_fault_ff) && $stable(comm_fault_ff))
   `TBSMR_ASSERT_IMP(a_zero_unless_ok, clock, reset, rsp_valid_ff && (kind_ff != KIND_CUR_OK), (current_ff == '0) && (point_ff == '0))
   `TBSMR_ASSERT_IMP(a_bad_counted, clock, reset, rsp_valid_ff && (kind_ff == KIND_CUR_BAD), bad_count_ff != 16'h0000)
   `TBSMR_ASSERT_IMP(a_started_flag, clock, reset, rsp_valid_ff && (kind_ff == KIND_STARTED), started_ff)
   `TBSMR_ASSERT_IMP(a_fault_flags, clock, reset, rsp_valid_ff && ((kind_ff == KIND_STOP_FAULT) || (kind_ff == KIND_COMM_FAULT)), stop_fault_ff || comm_fault_ff)

endmodule

### hw/rtl/tbsmr_decode.sv
// classifies one framed two-byte message and scales a current reading
// depends on tbsmr_pkg
module tbsmr_decode (
   input  logic [7:0]           first_byte,
   input  logic [7:0]           second_byte,
   input  tbsmr_pkg::cfg_type   cfg,
   output tbsmr_pkg::decode_type dec
);
   import tbsmr_pkg::*;

   logic [15:0]              code;
   logic [7:0]               check;
   logic [PointWidth-1:0]    point;
   logic signed [PointWidth:0] diff;
   logic signed [CurrentWidth:0] product;

   assign code  = {first_byte, second_byte};
   assign check = (second_byte & CHECK_HIGH_MASK) ^ ((first_byte & CHECK_LOW_MASK) << 3);
   assign point = ((({2'b00, first_byte}) & POINT_LOW_MASK) >> 5)
                | ((({2'b00, second_byte}) & POINT_HIGH_MASK) << 2);
   assign diff    = $signed({1'b0, point}) - $signed({1'b0, cfg.zero_point});
   assign product = diff * $signed({1'b0, cfg.current_step});

   always_comb begin
      dec.kind          = KIND_CUR_BAD;
      dec.scale_point   = '0;
      dec.current_value = '0;
      if (code == cfg.started_code) begin
         dec.kind = KIND_STARTED;
      end else if (code == cfg.stopped_code) begin
         dec.kind = KIND_STOPPED;
      end else if (code == cfg.stop_fault_code) begin
         dec.kind = KIND_STOP_FAULT;
      end else if (code == cfg.comm_fault_code) begin
         dec.kind = KIND_COMM_FAULT;
      end else if (check == CHECK_HIGH_MASK) begin
         dec.kind          = KIND_CUR_OK;
         dec.scale_point   = point;
         dec.current_value = product[CurrentWidth-1:0];
      end
   end

endmodule
